>>> sv/lrg_pkg.sv
// Package for the linear ramp generator: widths, command codes, reset values
// and the request struct shared by the top level and the divider.
// No dependencies.
package lrg_pkg;

  localparam int LEVEL_W    = 32;            // signed Q16.16 level
  localparam int STEP_W     = LEVEL_W + 2;   // signed Q18.16 step
  localparam int DIST_W     = LEVEL_W + 1;   // target - current, exact
  localparam int COUNT_BITS = 20;            // grain counter
  localparam int GRAIN_W    = 16;            // grain_period register
  localparam int TIME_W     = 20;            // ramp_time field
  localparam int DIV_W      = DIST_W;        // divider dividend / quotient width
  localparam int DIV_CNT_W  = $clog2(DIV_W + 1);
  localparam int IN_TDATA_W = ((LEVEL_W + TIME_W + 7) / 8) * 8;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [GRAIN_W-1:0] GRAIN_RESET = GRAIN_W'(20);

  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_GO   = 2'd1,
    CMD_SET  = 2'd2,
    CMD_STOP = 2'd3
  } cmd_t;

  // register index, taken from paddr[2]
  localparam logic REG_IDX_GRAIN = 1'b0;

  typedef struct packed {
    logic start;     // load operands and begin
    logic short_op;  // dividend is only TIME_W bits wide
  } div_req_t;

endpackage

>>> sv/linear_ramp_generator.sv
// Linear ramp generator top level: command stream in, level stream out.
// Depends on lrg_pkg, lrg_cfg, lrg_div.
//
// Usage:
//   Input transactions carry a command in in_tuser (tick, go, set, stop) with
//   the level and ramp time in in_tdata. A go computes grains = ramp_time /
//   grain_period and step = (target - level) / grains on one shared
//   bit-serial divider, then arms the ramp. Each armed tick emits one output
//   transaction: the new level on out_tdata, out_tlast high on the final
//   grain, where the level lands exactly on the target.
// Timing:
//   tick, set, stop: a tick result is registered and appears the cycle after accept.
//   go: in_tready low while the divider runs 20 steps for the grain count,
//   then 33 steps for the step size, plus handoff.
//   A go that yields zero grains jumps to the target after the first pass.
// Stall: one output register; while it holds a result the receiver has not
//   taken, in_tready follows out_tready, so a new command enters the same
//   cycle the old result leaves.
// Reset: synchronous active-low; level, target, step, count clear to zero,
//   ramp disarmed, grain_period back to 20.
// Config: grain_period at byte address 0; write only while idle.
module linear_ramp_generator import lrg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // command stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,   // [31:0] level_in, [51:32] ramp_time, rest 0
  input  logic [1:0]            in_tuser,   // [1:0] cmd
  // level stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [LEVEL_W-1:0]    out_tdata,  // [31:0] level_out
  output logic                  out_tlast,  // ramp_done
  // configuration
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_GRAIN,   // ramp_time / grain_period
    ST_STEP     // |distance| / grains
  } state_t;

  state_t                    state_r;
  logic signed [LEVEL_W-1:0] cur_r, tgt_r;
  logic signed [STEP_W-1:0]  step_r;
  logic [COUNT_BITS-1:0]     grains_r;
  logic                      armed_r;
  logic                      neg_r;
  logic                      out_valid_r;
  logic [LEVEL_W-1:0]        out_level_r;
  logic                      out_done_r;

  logic [GRAIN_W-1:0]        grain_period;
  div_req_t                  div_req;
  logic [DIV_W-1:0]          div_dividend;
  logic [COUNT_BITS-1:0]     div_divisor;
  logic                      div_done;
  logic [DIV_W-1:0]          div_q;

  cmd_t                      cmd;
  logic signed [LEVEL_W-1:0] level_in;
  logic [TIME_W-1:0]         ramp_time;
  logic                      acc;
  logic                      tick_fire;

  logic signed [STEP_W:0]    sum;
  logic signed [LEVEL_W-1:0] sum_clamp;
  logic [COUNT_BITS-1:0]     grains_dec;
  logic signed [DIST_W-1:0]  span;
  logic [DIST_W-1:0]         dist_mag;
  logic [COUNT_BITS-1:0]     grain_cnt;
  logic [STEP_W-1:0]         step_mag;

  lrg_cfg u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (cfg_psel),
    .penable      (cfg_penable),
    .pwrite       (cfg_pwrite),
    .paddr        (cfg_paddr),
    .pwdata       (cfg_pwdata),
    .prdata       (cfg_prdata),
    .pready       (cfg_pready),
    .grain_period (grain_period)
  );

  lrg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  assign cmd       = cmd_t'(in_tuser);
  assign level_in  = in_tdata[LEVEL_W-1:0];
  assign ramp_time = in_tdata[LEVEL_W +: TIME_W];

  // commands enter only when idle and the output slot is free or draining
  assign in_tready = (state_r == ST_IDLE) && (!out_valid_r || out_tready);
  assign acc       = in_tvalid && in_tready;
  assign tick_fire = acc && (cmd == CMD_TICK) && armed_r;

  // tick datapath: one wide add, clamp, count down
  always_comb begin
    sum = {{(STEP_W+1-LEVEL_W){cur_r[LEVEL_W-1]}}, cur_r} + {step_r[STEP_W-1], step_r};
    if (sum > (STEP_W+1)'(signed'({1'b0, {(LEVEL_W-1){1'b1}}}))) begin
      sum_clamp = {1'b0, {(LEVEL_W-1){1'b1}}};
    end else if (sum < -((STEP_W+1)'(signed'({1'b0, {(LEVEL_W-1){1'b1}}})) + 1)) begin
      sum_clamp = {1'b1, {(LEVEL_W-1){1'b0}}};
    end else begin
      sum_clamp = sum[LEVEL_W-1:0];
    end
    grains_dec = grains_r - 1'b1;
  end

  // step operands: exact distance and its magnitude
  always_comb begin
    span      = {tgt_r[LEVEL_W-1], tgt_r} - {cur_r[LEVEL_W-1], cur_r};
    dist_mag  = span[DIST_W-1] ? DIST_W'(-span) : DIST_W'(span);
    grain_cnt = div_q[COUNT_BITS-1:0];
    step_mag  = {1'b0, div_q};
  end

  // divider request: grain pass on go, step pass when a nonzero count lands
  always_comb begin
    div_req      = '0;
    div_dividend = DIV_W'(ramp_time);
    div_divisor  = (grain_period == '0) ? COUNT_BITS'(1) : COUNT_BITS'(grain_period);
    if (state_r == ST_IDLE) begin
      div_req.start    = acc && (cmd == CMD_GO);
      div_req.short_op = 1'b1;
    end else if (state_r == ST_GRAIN) begin
      div_req.start    = div_done && (grain_cnt != '0);
      div_req.short_op = 1'b0;
      div_dividend     = dist_mag;
      div_divisor      = grain_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cur_r       <= '0;
      tgt_r       <= '0;
      step_r      <= '0;
      grains_r    <= '0;
      armed_r     <= 1'b0;
      neg_r       <= 1'b0;
      out_valid_r <= 1'b0;
      out_done_r  <= 1'b0;
      out_level_r <= '0;
    end else begin
      // a new tick result loads the slot; otherwise it drains on out_tready
      out_valid_r <= tick_fire || (out_valid_r && !out_tready);
      unique case (state_r)
        ST_IDLE: begin
          if (acc) begin
            unique case (cmd)
              CMD_TICK: begin
                if (armed_r) begin
                  grains_r <= grains_dec;
                  if (grains_dec == '0) begin
                    // last grain: land exactly on the target
                    cur_r       <= tgt_r;
                    armed_r     <= 1'b0;
                    out_level_r <= tgt_r;
                    out_done_r  <= 1'b1;
                  end else begin
                    cur_r       <= sum_clamp;
                    out_level_r <= sum_clamp;
                    out_done_r  <= 1'b0;
                  end
                end
              end
              CMD_GO: begin
                tgt_r   <= level_in;
                state_r <= ST_GRAIN;
              end
              CMD_SET: begin
                cur_r   <= level_in;
                armed_r <= 1'b0;
              end
              CMD_STOP: begin
                armed_r <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        ST_GRAIN: begin
          if (div_done) begin
            if (grain_cnt == '0) begin
              // too short for one grain: jump straight to the target
              cur_r    <= tgt_r;
              step_r   <= '0;
              grains_r <= '0;
              armed_r  <= 1'b0;
              state_r  <= ST_IDLE;
            end else begin
              grains_r <= grain_cnt;
              neg_r    <= span[DIST_W-1];
              state_r  <= ST_STEP;
            end
          end
        end
        ST_STEP: begin
          if (div_done) begin
            step_r  <= neg_r ? -$signed(step_mag) : $signed(step_mag);
            armed_r <= 1'b1;
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_level_r;
  assign out_tlast  = out_done_r;

endmodule

>>> sv/lrg_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Unsigned DIV_W-bit dividend by COUNT_BITS-bit divisor. Depends on lrg_pkg.
module lrg_div import lrg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  div_req_t              req,
  input  logic [DIV_W-1:0]      dividend,
  input  logic [COUNT_BITS-1:0] divisor,
  output logic                  done,
  output logic [DIV_W-1:0]      quotient
);

  logic [DIV_W-1:0]      q_r, q_nxt;
  logic [COUNT_BITS-1:0] rem_r, rem_nxt;
  logic [COUNT_BITS-1:0] dvs_r;
  logic [DIV_CNT_W-1:0]  cnt_r;
  logic                  busy_r;
  logic                  done_r;

  logic [COUNT_BITS:0]   rem_sh;
  logic [COUNT_BITS+1:0] diff;
  logic                  ge;

  always_comb begin
    rem_sh  = {rem_r, q_r[DIV_W-1]};
    diff    = {1'b0, rem_sh} - {2'b00, dvs_r};
    ge      = ~diff[COUNT_BITS+1];
    rem_nxt = ge ? diff[COUNT_BITS-1:0] : rem_sh[COUNT_BITS-1:0];
    q_nxt   = {q_r[DIV_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.short_op ? DIV_CNT_W'(TIME_W) : DIV_CNT_W'(DIV_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      dvs_r <= divisor;
      // short form: park the narrow dividend at the top so fewer steps suffice
      q_r   <= req.short_op ? {dividend[TIME_W-1:0], {(DIV_W-TIME_W){1'b0}}} : dividend;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

>>> sv/lrg_cfg.sv
// APB-style register slave holding grain_period.
// Depends on lrg_pkg.
module lrg_cfg import lrg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [GRAIN_W-1:0]    grain_period
);

  logic [GRAIN_W-1:0] grain_r;
  logic               hit;

  assign hit    = (paddr[2] == REG_IDX_GRAIN);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grain_r <= GRAIN_RESET;
    end else if (psel && penable && pwrite && pready && hit) begin
      grain_r <= pwdata[GRAIN_W-1:0];
    end
  end

  assign prdata       = hit ? CFG_DATA_W'(grain_r) : '0;
  assign grain_period = grain_r;

endmodule

>>> sv/lrg_checker.sv
// Port-level checker for linear_ramp_generator, bound to the top level.
// Depends on lrg_pkg.
module lrg_checker import lrg_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic [1:0]            in_tuser,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [LEVEL_W-1:0]    out_tdata,
  input logic                  out_tlast
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output changed while stalled");

  // a go keeps the port busy while the divider runs
  a_go_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == CMD_GO) |=> !in_tready)
    else $error("command accepted during go computation");

  // a fresh result only follows an accepted tick
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready && (in_tuser == CMD_TICK)))
    else $error("result without a tick");

  // no new command while a result sits stalled
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input accepted over a stalled result");

endmodule

bind linear_ramp_generator lrg_checker u_lrg_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
